### rtl/remote_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// Remote frame decoder assertion macros
// Shared property forms for the decoder's concurrent checks. All of them are
// clocked on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REMOTE_FRAME_DECODER_DEFINES_SVH
`define REMOTE_FRAME_DECODER_DEFINES_SVH

// A condition that must hold at every clock edge.
`define RFD_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that, once seen, forces another one on the next clock edge.
`define RFD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// A condition that, once seen, forces another one on the same clock edge.
`define RFD_ASSERT_IMPLIES(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Remote frame decoder package
// Shared constants, register indexes, codes and types of the decoder.
// ----------------------------------------------------------------------------
package rfd_pkg;

	// Frame window length and depth of the frame queue.
	localparam int FRAME_BYTES_DEF = 18;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 10;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STICK_LIMIT = 8'd3;

	// Configuration reset values.
	localparam logic [3:0] IDLE_LIMIT_RST  = 4'd10;
	localparam logic [4:0] MIN_FRAME_RST   = 5'd17;
	localparam logic [9:0] DEADBAND_RST    = 10'd10;
	localparam logic [9:0] STICK_LIMIT_RST = 10'd660;

	// Input opcodes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Saturation points of the frame counters.
	localparam logic [4:0] COUNT_MAX = 5'd31;
	localparam logic [3:0] RUN_MAX   = 4'd15;

	// Configuration register set.
	typedef struct packed {
		logic [3:0] idle_limit;
		logic [4:0] min_frame_bytes;
		logic [9:0] deadband;
		logic [9:0] stick_limit;
	} cfg_t;

	// Frame queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/rfd_front.sv
// ----------------------------------------------------------------------------
// Remote frame decoder front end
// Accepts bytes and empty polls, keeps the byte window and frame counters,
// and queues a window snapshot when the idle run closes a frame.
// ----------------------------------------------------------------------------
module rfd_front
	import rfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [7:0]                  rx_byte,
	input  cfg_t                        cfg,
	input  q_stat_t                     q_stat,
	output logic                        push,
	output logic                        push_short,
	output logic [FRAME_BYTES-1:0][7:0] push_window
);

	logic [FRAME_BYTES-1:0][7:0] win_q;
	logic [4:0]                  count_q;
	logic [3:0]                  run_q;
	logic                        accept;
	logic [3:0]                  run_inc;
	logic                        frame_end;

	// Input transfers pause only while the frame queue is full.
	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	// Idle run after this poll, and whether it closes the frame.
	assign run_inc   = (run_q == RUN_MAX) ? run_q : run_q + 4'd1;
	assign frame_end = (run_inc >= cfg.idle_limit);

	assign push        = accept && (opcode == OP_POLL) && frame_end;
	assign push_short  = (count_q < cfg.min_frame_bytes);
	assign push_window = win_q;

	// Window shift and frame counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			count_q <= '0;
			run_q   <= '0;
		end else if (accept) begin
			if (opcode == OP_BYTE) begin
				win_q <= {rx_byte, win_q[FRAME_BYTES-1:1]};
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 5'd1;
				end
				run_q <= '0;
			end else if (frame_end) begin
				run_q   <= '0;
				count_q <= '0;
			end else begin
				run_q <= run_inc;
			end
		end
	end

endmodule

### rtl/rfd_queue.sv
// ----------------------------------------------------------------------------
// Remote frame decoder frame queue
// Small first-in first-out buffer of frame snapshots between the front end
// and the decode stage.
// ----------------------------------------------------------------------------
module rfd_queue
	import rfd_pkg::*;
#(
	parameter int WIDTH = 8 * FRAME_BYTES_DEF + 1,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_stat_t          q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (level_q == LVL_FULL);
	assign q_stat.empty = (level_q == '0);

	// Entry storage; the caller never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

### rtl/rfd_back.sv
// ----------------------------------------------------------------------------
// Remote frame decoder decode stage
// Takes queued frame snapshots, decodes sticks, switches, mouse, keys and
// wheel, keeps the held values and presents results in an output register.
// ----------------------------------------------------------------------------
module rfd_back
	import rfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  q_stat_t                     q_stat,
	output logic                        pop,
	input  logic                        pop_short,
	input  logic [FRAME_BYTES-1:0][7:0] pop_window,
	input  cfg_t                        cfg,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [10:0]          stick_a,
	output logic signed [10:0]          stick_b,
	output logic signed [10:0]          stick_c,
	output logic signed [10:0]          stick_d,
	output logic [3:0]                  switches,
	output logic signed [15:0]          mouse_x,
	output logic signed [15:0]          mouse_y,
	output logic signed [15:0]          mouse_z,
	output logic [15:0]                 mouse_buttons,
	output logic [15:0]                 key_mask,
	output logic signed [10:0]          wheel,
	output logic [1:0]                  status
);

	logic [FRAME_BYTES-1:0][7:0] b;
	logic [3:0][10:0]            raw;
	logic [3:0][10:0]            ch;
	logic [3:0]                  over;
	logic                        bad;
	logic signed [16:0]          w_full;
	logic signed [16:0]          w_lim;
	logic signed [16:0]          w_clamp;

	logic        out_valid_q;
	logic [10:0] stick_a_q;
	logic [10:0] stick_b_q;
	logic [10:0] stick_c_q;
	logic [10:0] stick_d_q;
	logic [3:0]  switches_q;
	logic [15:0] mouse_x_q;
	logic [15:0] mouse_y_q;
	logic [15:0] mouse_z_q;
	logic [15:0] mouse_buttons_q;
	logic [15:0] key_mask_q;
	logic [10:0] wheel_q;
	logic [1:0]  status_q;

	logic [15:0] held_x_q;
	logic [15:0] held_y_q;
	logic [15:0] held_z_q;
	logic [15:0] held_buttons_q;
	logic [15:0] held_key_q;
	logic [10:0] held_wheel_q;

	// A frame is taken when one waits and the output register is free.
	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);
	assign b   = pop_window;

	// Eleven-bit stick fields packed little-endian across bytes 0 to 5.
	assign raw[0] = {b[1][2:0], b[0]};
	assign raw[1] = {b[2][5:0], b[1][7:3]};
	assign raw[2] = {b[4][0], b[3], b[2][7:6]};
	assign raw[3] = {b[5][3:0], b[4][7:1]};

	// Centre each stick on 1024, zero it inside the deadband, check its range.
	always_comb begin
		logic [10:0] v;
		logic [10:0] mag;
		for (int k = 0; k < 4; k++) begin
			v   = {~raw[k][10], raw[k][9:0]};
			mag = v[10] ? (~v + 11'd1) : v;
			if (mag <= {1'b0, cfg.deadband}) begin
				ch[k]   = '0;
				over[k] = 1'b0;
			end else begin
				ch[k]   = v;
				over[k] = (mag > {1'b0, cfg.stick_limit});
			end
		end
	end
	assign bad = |over;

	// Wheel offset by 1024 and clamped to the stick limit on both sides.
	assign w_full = $signed({1'b0, b[17], b[16]}) - 17'sd1024;
	assign w_lim  = $signed({7'd0, cfg.stick_limit});
	always_comb begin
		if (w_full > w_lim) begin
			w_clamp = w_lim;
		end else if (w_full < -w_lim) begin
			w_clamp = -w_lim;
		end else begin
			w_clamp = w_full;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Held mouse, key and wheel values carried between frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q       <= '0;
			held_y_q       <= '0;
			held_z_q       <= '0;
			held_buttons_q <= '0;
			held_key_q     <= '0;
			held_wheel_q   <= '0;
		end else if (pop) begin
			if (pop_short) begin
				held_x_q       <= '0;
				held_y_q       <= '0;
				held_z_q       <= '0;
				held_buttons_q <= '0;
				held_key_q     <= '0;
				held_wheel_q   <= '0;
			end else if (!bad) begin
				held_x_q       <= {b[7], b[6]};
				held_y_q       <= {b[9], b[8]};
				held_z_q       <= {b[11], b[10]};
				held_buttons_q <= {b[13], b[12]};
				held_key_q     <= {b[15], b[14]};
				held_wheel_q   <= w_clamp[10:0];
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_short) begin
				stick_a_q       <= '0;
				stick_b_q       <= '0;
				stick_c_q       <= '0;
				stick_d_q       <= '0;
				switches_q      <= '0;
				mouse_x_q       <= '0;
				mouse_y_q       <= '0;
				mouse_z_q       <= '0;
				mouse_buttons_q <= '0;
				key_mask_q      <= '0;
				wheel_q         <= '0;
				status_q        <= ST_SHORT;
			end else begin
				stick_a_q  <= ch[0];
				stick_b_q  <= ch[1];
				stick_c_q  <= ch[2];
				stick_d_q  <= ch[3];
				switches_q <= b[5][7:4];
				if (bad) begin
					mouse_x_q       <= held_x_q;
					mouse_y_q       <= held_y_q;
					mouse_z_q       <= held_z_q;
					mouse_buttons_q <= held_buttons_q;
					key_mask_q      <= held_key_q;
					wheel_q         <= held_wheel_q;
					status_q        <= ST_RANGE;
				end else begin
					mouse_x_q       <= {b[7], b[6]};
					mouse_y_q       <= {b[9], b[8]};
					mouse_z_q       <= {b[11], b[10]};
					mouse_buttons_q <= {b[13], b[12]};
					key_mask_q      <= {b[15], b[14]};
					wheel_q         <= w_clamp[10:0];
					status_q        <= ST_VALID;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stick_a       = $signed(stick_a_q);
	assign stick_b       = $signed(stick_b_q);
	assign stick_c       = $signed(stick_c_q);
	assign stick_d       = $signed(stick_d_q);
	assign switches      = switches_q;
	assign mouse_x       = $signed(mouse_x_q);
	assign mouse_y       = $signed(mouse_y_q);
	assign mouse_z       = $signed(mouse_z_q);
	assign mouse_buttons = mouse_buttons_q;
	assign key_mask      = key_mask_q;
	assign wheel         = $signed(wheel_q);
	assign status        = status_q;

endmodule

### rtl/remote_frame_decoder.sv
// ----------------------------------------------------------------------------
// Remote frame decoder
// The block takes one item, a received byte or an empty poll, in every clock
// cycle unless in_stall is high. Bytes fill an 18-byte window; when the run of
// empty polls reaches idle_limit the window is queued for decode, and its
// result is decoded from the queue head into an output register and held
// there until the output transfer completes. A two-entry frame queue sits
// between the byte front end and the decode stage, so input transfers stall
// only while both queue entries are occupied. There is no clearing pass after
// reset; configuration writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
`include "remote_frame_decoder_defines.svh"

module remote_frame_decoder
	import rfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [7:0]             rx_byte,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [10:0]     stick_a,
	output logic signed [10:0]     stick_b,
	output logic signed [10:0]     stick_c,
	output logic signed [10:0]     stick_d,
	output logic [3:0]             switches,
	output logic signed [15:0]     mouse_x,
	output logic signed [15:0]     mouse_y,
	output logic signed [15:0]     mouse_z,
	output logic [15:0]            mouse_buttons,
	output logic [15:0]            key_mask,
	output logic signed [10:0]     wheel,
	output logic [1:0]             status
);

	localparam int ENTRY_W = 8 * FRAME_BYTES + 1;

	cfg_t                        cfg_q;
	q_stat_t                     q_stat;
	logic                        push;
	logic                        push_short;
	logic [FRAME_BYTES-1:0][7:0] push_window;
	logic                        pop;
	logic [ENTRY_W-1:0]          pop_data;

	// Configuration registers; every write transfer completes at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_limit      <= IDLE_LIMIT_RST;
			cfg_q.min_frame_bytes <= MIN_FRAME_RST;
			cfg_q.deadband        <= DEADBAND_RST;
			cfg_q.stick_limit     <= STICK_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IDLE_LIMIT:  cfg_q.idle_limit      <= cfg_data[3:0];
				CFG_MIN_FRAME:   cfg_q.min_frame_bytes <= cfg_data[4:0];
				CFG_DEADBAND:    cfg_q.deadband        <= cfg_data[9:0];
				CFG_STICK_LIMIT: cfg_q.stick_limit     <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Byte front end.
	rfd_front #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.rx_byte     (rx_byte),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_short  (push_short),
		.push_window (push_window)
	);

	// Frame queue.
	rfd_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_short, push_window}),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Decode stage and result register.
	rfd_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop           (pop),
		.pop_short     (pop_data[ENTRY_W-1]),
		.pop_window    (pop_data[ENTRY_W-2:0]),
		.cfg           (cfg_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stick_a       (stick_a),
		.stick_b       (stick_b),
		.stick_c       (stick_c),
		.stick_d       (stick_d),
		.switches      (switches),
		.mouse_x       (mouse_x),
		.mouse_y       (mouse_y),
		.mouse_z       (mouse_z),
		.mouse_buttons (mouse_buttons),
		.key_mask      (key_mask),
		.wheel         (wheel),
		.status        (status)
	);

	// A short frame result carries nothing but its status.
	`RFD_ASSERT_IMPLIES(a_short_zero, out_valid && (status == ST_SHORT),
		(stick_a == 11'sd0) && (stick_b == 11'sd0) && (stick_c == 11'sd0) &&
		(stick_d == 11'sd0) && (switches == 4'd0) && (mouse_x == 16'sd0) &&
		(mouse_y == 16'sd0) && (mouse_z == 16'sd0) && (mouse_buttons == 16'd0) &&
		(key_mask == 16'd0) && (wheel == 11'sd0), "short frame result has nonzero fields")

	// A valid result has its wheel inside the stick limit.
	`RFD_ASSERT_IMPLIES(a_wheel_clamped, out_valid && (status == ST_VALID),
		($signed(wheel) <= $signed({1'b0, cfg_q.stick_limit})) &&
		($signed(wheel) >= -$signed({1'b0, cfg_q.stick_limit})), "wheel outside clamp bound")

	// A byte transfer never queues a frame.
	`RFD_ASSERT_NEXT(a_byte_no_frame,
		in_valid && !in_stall && (opcode == OP_BYTE) && q_stat.empty, q_stat.empty,
		"byte transfer queued a frame")

	// Status never takes the unused code.
	`RFD_ASSERT_ALWAYS(a_status_code,
		!out_valid || (status == ST_VALID) || (status == ST_SHORT) || (status == ST_RANGE),
		"result status code out of range")

endmodule

### tb/sv/remote_frame_decoder_test.sv
// ----------------------------------------------------------------------------
// Remote frame decoder testbench
// Sends received bytes and empty polls through the input channel and runs a
// bit-accurate frame decoder alongside the block. Each decoded frame that the
// block returns is compared field by field with the oldest predicted frame.
// The run covers several register settings, the extreme ones among them, and
// both channels pause at random.
// ----------------------------------------------------------------------------
module remote_frame_decoder_test
	import rfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One decoded frame as it leaves the block.
	typedef struct packed {
		logic signed [10:0] stick_a;
		logic signed [10:0] stick_b;
		logic signed [10:0] stick_c;
		logic signed [10:0] stick_d;
		logic [3:0]         switches;
		logic signed [15:0] mouse_x;
		logic signed [15:0] mouse_y;
		logic signed [15:0] mouse_z;
		logic [15:0]        mouse_buttons;
		logic [15:0]        key_mask;
		logic signed [10:0] wheel;
		logic [1:0]         status;
	} frame_result_t;

	// Frame decoder model and the queue of frames it has predicted.
	class frame_scoreboard;
		cfg_t          cfg;
		logic [7:0]    window [FRAME_BYTES_DEF];
		logic [4:0]    byte_count;
		logic [3:0]    poll_run;
		logic [15:0]   held_x, held_y, held_z, held_buttons, held_key;
		logic [10:0]   held_wheel;
		frame_result_t pending_frames [$];
		int            fail_count;
		int            frames_predicted;
		int            frames_checked;
		int            short_frames;
		int            range_frames;

		function new();
			cfg.idle_limit      = IDLE_LIMIT_RST;
			cfg.min_frame_bytes = MIN_FRAME_RST;
			cfg.deadband        = DEADBAND_RST;
			cfg.stick_limit     = STICK_LIMIT_RST;
			foreach (window[i])
				window[i] = '0;
			byte_count   = '0;
			poll_run     = '0;
			held_x       = '0;
			held_y       = '0;
			held_z       = '0;
			held_buttons = '0;
			held_key     = '0;
			held_wheel   = '0;
		endfunction

		task report(string msg);
			if (fail_count < 50)
				$display("MISMATCH: %s", msg);
			fail_count++;
		endtask

		function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_IDLE_LIMIT:  cfg.idle_limit      = data[3:0];
				CFG_MIN_FRAME:   cfg.min_frame_bytes = data[4:0];
				CFG_DEADBAND:    cfg.deadband        = data[9:0];
				CFG_STICK_LIMIT: cfg.stick_limit     = data[9:0];
				default: ;
			endcase
		endfunction

		// Centre a raw channel on 1024 and zero it inside the deadband.
		function int centre(logic [10:0] raw);
			int c;
			c = int'(raw) - 1024;
			if ((c < 0 ? -c : c) <= int'(cfg.deadband))
				c = 0;
			return c;
		endfunction

		// Advance the model by one accepted input transfer.
		function void take_item(logic op, logic [7:0] data);
			logic [47:0]   head;
			int            ch [4];
			int            mag;
			int            w;
			int            lim;
			bit            bad;
			frame_result_t r;
			if (op == OP_BYTE) begin
				for (int i = 0; i < FRAME_BYTES_DEF - 1; i++)
					window[i] = window[i+1];
				window[FRAME_BYTES_DEF-1] = data;
				if (byte_count != COUNT_MAX)
					byte_count++;
				poll_run = '0;
				return;
			end
			if (poll_run != RUN_MAX)
				poll_run++;
			if (poll_run < cfg.idle_limit)
				return;

			// The run of polls closes the frame: decode the window.
			head = {window[5], window[4], window[3], window[2], window[1], window[0]};
			bad = 1'b0;
			for (int k = 0; k < 4; k++) begin
				ch[k] = centre(head[11*k +: 11]);
				mag = ch[k] < 0 ? -ch[k] : ch[k];
				if (mag > int'(cfg.stick_limit))
					bad = 1'b1;
			end
			r = '0;
			if (byte_count < cfg.min_frame_bytes) begin
				held_x       = '0;
				held_y       = '0;
				held_z       = '0;
				held_buttons = '0;
				held_key     = '0;
				held_wheel   = '0;
				r.status     = ST_SHORT;
				short_frames++;
			end else begin
				// Sticks in range refresh the held values, otherwise they repeat.
				if (!bad) begin
					w = int'({window[17], window[16]}) - 1024;
					lim = int'(cfg.stick_limit);
					if (w > lim)
						w = lim;
					else if (w < -lim)
						w = -lim;
					held_x       = {window[7], window[6]};
					held_y       = {window[9], window[8]};
					held_z       = {window[11], window[10]};
					held_buttons = {window[13], window[12]};
					held_key     = {window[15], window[14]};
					held_wheel   = w[10:0];
				end else begin
					range_frames++;
				end
				r.stick_a       = ch[0][10:0];
				r.stick_b       = ch[1][10:0];
				r.stick_c       = ch[2][10:0];
				r.stick_d       = ch[3][10:0];
				r.switches      = window[5][7:4];
				r.mouse_x       = held_x;
				r.mouse_y       = held_y;
				r.mouse_z       = held_z;
				r.mouse_buttons = held_buttons;
				r.key_mask      = held_key;
				r.wheel         = held_wheel;
				r.status        = bad ? ST_RANGE : ST_VALID;
			end
			pending_frames.push_back(r);
			frames_predicted++;
			poll_run = '0;
			byte_count = '0;
		endfunction

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("frame %0d %s: got %0h, expected %0h",
					frames_checked, name, got, want));
		endtask

		// Compare one output transfer with the oldest predicted frame.
		task check_result(frame_result_t got);
			frame_result_t want;
			if (pending_frames.size() == 0) begin
				report($sformatf("frame result with none predicted, status %0d", got.status));
				return;
			end
			want = pending_frames.pop_front();
			check_field("stick_a", got.stick_a, want.stick_a);
			check_field("stick_b", got.stick_b, want.stick_b);
			check_field("stick_c", got.stick_c, want.stick_c);
			check_field("stick_d", got.stick_d, want.stick_d);
			check_field("switches", got.switches, want.switches);
			check_field("mouse_x", got.mouse_x, want.mouse_x);
			check_field("mouse_y", got.mouse_y, want.mouse_y);
			check_field("mouse_z", got.mouse_z, want.mouse_z);
			check_field("mouse_buttons", got.mouse_buttons, want.mouse_buttons);
			check_field("key_mask", got.key_mask, want.key_mask);
			check_field("wheel", got.wheel, want.wheel);
			check_field("status", got.status, want.status);
			frames_checked++;
		endtask

		task close();
			if (pending_frames.size() != 0)
				report($sformatf("%0d predicted frames never arrived", pending_frames.size()));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   opcode;
	logic [7:0]             rx_byte;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [10:0]     stick_a, stick_b, stick_c, stick_d;
	logic [3:0]             switches;
	logic signed [15:0]     mouse_x, mouse_y, mouse_z;
	logic [15:0]            mouse_buttons;
	logic [15:0]            key_mask;
	logic signed [10:0]     wheel;
	logic [1:0]             status;

	frame_scoreboard sb = new();
	bit              quiet = 1'b0;
	int              items_sent = 0;
	int              config_writes = 0;

	remote_frame_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.rx_byte       (rx_byte),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stick_a       (stick_a),
		.stick_b       (stick_b),
		.stick_c       (stick_c),
		.stick_d       (stick_d),
		.switches      (switches),
		.mouse_x       (mouse_x),
		.mouse_y       (mouse_y),
		.mouse_z       (mouse_z),
		.mouse_buttons (mouse_buttons),
		.key_mask      (key_mask),
		.wheel         (wheel),
		.status        (status)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side: random stalls and the check of every output transfer.
	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.stick_a       = stick_a;
			got.stick_b       = stick_b;
			got.stick_c       = stick_c;
			got.stick_d       = stick_d;
			got.switches      = switches;
			got.mouse_x       = mouse_x;
			got.mouse_y       = mouse_y;
			got.mouse_z       = mouse_z;
			got.mouse_buttons = mouse_buttons;
			got.key_mask      = key_mask;
			got.wheel         = wheel;
			got.status        = status;
			sb.check_result(got);
		end
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 9);
	end

	// Offer one item, with an occasional gap first, and wait for its transfer.
	task push_item(logic op, logic [7:0] data);
		if (!quiet) begin
			while ($urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode   <= op;
		rx_byte  <= data;
		do
			@(posedge clk);
		while (in_stall);
		sb.take_item(op, data);
		items_sent++;
	endtask

	// Write all four registers back to back, then release the channel.
	task write_config(int idle, int min_bytes, int db, int sl);
		logic [CFG_INDEX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0]  vals [4];
		idx  = '{CFG_IDLE_LIMIT, CFG_MIN_FRAME, CFG_DEADBAND, CFG_STICK_LIMIT};
		vals = '{CFG_DATA_W'(idle), CFG_DATA_W'(min_bytes), CFG_DATA_W'(db), CFG_DATA_W'(sl)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			sb.set_reg(idx[i], vals[i]);
			config_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// Let every predicted frame come out and the pipeline drain.
	task settle();
		in_valid <= 1'b0;
		while (sb.pending_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Raw stick value: mostly in range, some near the deadband, some anywhere.
	function automatic logic [10:0] pick_stick();
		int lim, db, off;
		lim = int'(sb.cfg.stick_limit);
		db  = int'(sb.cfg.deadband);
		case ($urandom_range(9))
			0: return 11'($urandom);
			1, 2: off = $urandom_range(2 * db + 2) - (db + 1);
			default: off = $urandom_range(2 * lim) - lim;
		endcase
		off += 1024;
		if (off < 0)
			off = 0;
		if (off > 2047)
			off = 2047;
		return 11'(off);
	endfunction

	// Send a frame of nbytes bytes followed by npolls empty polls.
	task send_frame(int nbytes, int npolls);
		logic [7:0]  payload [FRAME_BYTES_DEF];
		logic [47:0] head;
		logic [15:0] wc;
		int          first;
		head = {4'($urandom_range(15)), pick_stick(), pick_stick(), pick_stick(), pick_stick()};
		for (int i = 0; i < 6; i++)
			payload[i] = head[8*i +: 8];
		for (int i = 6; i < 16; i++)
			payload[i] = 8'($urandom);
		if ($urandom_range(7) == 0)
			wc = 16'($urandom);
		else
			wc = 16'($urandom_range(2124));
		payload[16] = wc[7:0];
		payload[17] = wc[15:8];
		for (int i = 0; i < nbytes - FRAME_BYTES_DEF; i++)
			push_item(OP_BYTE, 8'($urandom));
		first = nbytes < FRAME_BYTES_DEF ? FRAME_BYTES_DEF - nbytes : 0;
		for (int i = first; i < FRAME_BYTES_DEF; i++)
			push_item(OP_BYTE, payload[i]);
		repeat (npolls) push_item(OP_POLL, 8'($urandom));
	endtask

	// One register setting: mostly complete frames, some broken ones and noise.
	task run_phase(int idle, int min_bytes, int db, int sl);
		int start, kind, nbytes;
		settle();
		write_config(idle, min_bytes, db, sl);
		start = items_sent;
		while (items_sent - start < 50) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				case ($urandom_range(19))
					0, 1, 2: nbytes = $urandom_range(3);
					3, 4, 5: nbytes = $urandom_range(17, 4);
					6, 7:    nbytes = $urandom_range(34, 19);
					default: nbytes = FRAME_BYTES_DEF;
				endcase
				send_frame(nbytes, sb.cfg.idle_limit);
			end else if (kind < 85) begin
				send_frame($urandom_range(20, 1), $urandom_range(sb.cfg.idle_limit - 1));
			end else begin
				repeat ($urandom_range(6, 1)) push_item(1'($urandom), 8'($urandom));
			end
		end
	endtask

	// Main sequence.
	initial begin
		logic [47:0] head;
		logic [7:0]  demo [FRAME_BYTES_DEF];
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= OP_BYTE;
		rx_byte   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every poll closes a frame; the window still holds its reset zeros.
		write_config(0, 0, 0, 1023);
		push_item(OP_POLL, 8'hA5);

		// Sticks at both ends of the range, extreme mouse values, wheel clamped high.
		head = {4'b1010, 11'd1023, 11'd1024, 11'd1, 11'd2047};
		for (int i = 0; i < 6; i++)
			demo[i] = head[8*i +: 8];
		demo[6:17] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
			8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		for (int i = 0; i < FRAME_BYTES_DEF; i++)
			push_item(OP_BYTE, demo[i]);
		push_item(OP_POLL, 8'h00);
		push_item(OP_POLL, 8'hFF);

		// A frame that is too short clears everything, the held values too.
		settle();
		write_config(2, 17, 10, 660);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_BYTE, 8'h5A);
		push_item(OP_POLL, 8'h00);
		push_item(OP_POLL, 8'h00);

		// Random part over fixed settings, the reset values and extreme ones among them, then random settings.
		run_phase(10, 17, 10, 660);
		run_phase(1, 18, 0, 1023);
		quiet = 1'b1;
		run_phase(15, 0, 1023, 0);
		quiet = 1'b0;
		run_phase(3, 31, 5, 700);
		while (items_sent < 400)
			run_phase($urandom_range(6, 1), $urandom_range(31), $urandom_range(40),
				$urandom_range(1023, 400));

		settle();
		repeat (20) @(posedge clk);
		sb.close();
		$display("Summary: %0d items sent, %0d register writes, %0d frames checked",
			items_sent, config_writes, sb.frames_checked);
		$display("Summary: %0d short frames, %0d frames with a stick out of range",
			sb.short_frames, sb.range_frames);
		if (sb.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog for a stuck handshake.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_front.sv
rtl/rfd_queue.sv
rtl/rfd_back.sv
rtl/remote_frame_decoder.sv
tb/sv/remote_frame_decoder_test.sv
